/* src/event_subscription_router_macros.svh */
// assertion macros shared by the event subscription router checks
`ifndef EVENT_SUBSCRIPTION_ROUTER_MACROS_SVH
`define EVENT_SUBSCRIPTION_ROUTER_MACROS_SVH

// same-cycle implication, quiet during reset
`define ESR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event router check failed");

// next-cycle implication, quiet during reset
`define ESR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event router check failed");

`endif

/* src/esr_pkg.sv */
// shared types and codes of the event subscription router
`default_nettype none

package esr_pkg;

  localparam int KIND_W   = 2;
  localparam int EVENT_W  = 16;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 2;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [EVENT_W-1:0]  event_t;
  typedef logic [ID_W-1:0]     id_t;
  typedef logic [STATUS_W-1:0] status_t;

  // operation codes
  localparam kind_t KIND_PUBLISH     = 2'd0;
  localparam kind_t KIND_SUBSCRIBE   = 2'd1;
  localparam kind_t KIND_UNSUBSCRIBE = 2'd2;

  // result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_INVALID   = 2'd1;
  localparam status_t ST_NO_ROOM   = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  // one result transaction
  typedef struct packed {
    status_t status;
    id_t     target;
    logic    target_valid;
    logic    last;
  } result_t;

  localparam id_t NULL_ID = 8'd0;

endpackage

`default_nettype wire

/* src/esr_ram.sv */
// generic single-write, single-read memory with registered read data
`default_nettype none

module esr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/esr_ctrl.sv */
// sequencer: slot search, subscriber list update and result register
`default_nettype none

module esr_ctrl #(
  parameter int TYPE_SLOTS = 16,
  parameter int PER_TYPE   = 8,
  localparam int SW     = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1,
  localparam int UW     = $clog2(TYPE_SLOTS + 1),
  localparam int PW     = (PER_TYPE > 1) ? $clog2(PER_TYPE) : 1,
  localparam int FW     = $clog2(PER_TYPE + 1),
  localparam int SLOT_W = FW + esr_pkg::EVENT_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire esr_pkg::kind_t         in_kind,
  input  wire esr_pkg::event_t        in_event_code,
  input  wire esr_pkg::id_t           in_subscriber,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output esr_pkg::result_t            out_res,
  output logic                        slot_we,
  output logic [SW-1:0]               slot_waddr,
  output logic [SLOT_W-1:0]           slot_wdata,
  output logic [SW-1:0]               slot_raddr,
  input  wire logic [SLOT_W-1:0]      slot_rdata,
  output logic                        sub_we,
  output logic [SW+PW-1:0]            sub_waddr,
  output esr_pkg::id_t                sub_wdata,
  output logic [SW+PW-1:0]            sub_raddr,
  input  wire esr_pkg::id_t           sub_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SRCH   = 3'd1;
  localparam logic [2:0] S_PEMIT  = 3'd2;
  localparam logic [2:0] S_USCAN  = 3'd3;
  localparam logic [2:0] S_USHIFT = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [UW-1:0]    used_r, used_nxt;
  logic [UW-1:0]    idx_r, idx_nxt;
  logic [FW-1:0]    h_r, h_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  esr_pkg::kind_t   kind_r, kind_nxt;
  esr_pkg::event_t  code_r, code_nxt;
  esr_pkg::id_t     id_r, id_nxt;
  esr_pkg::status_t status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  esr_pkg::result_t out_res_r, out_res_nxt;

  logic [FW-1:0]   rd_fill;
  esr_pkg::event_t rd_event;
  logic            hit, at_end, miss, found, h_end, out_free, tbl_full, slot_full;
  logic [FW-1:0]   h_prev;

  assign rd_fill   = slot_rdata[SLOT_W-1:esr_pkg::EVENT_W];
  assign rd_event  = slot_rdata[esr_pkg::EVENT_W-1:0];
  assign hit       = (rd_event == code_r);
  assign at_end    = ((idx_r + UW'(1)) == used_r);
  assign found     = (used_r != '0) && hit;
  assign miss      = (used_r == '0) || (!hit && at_end);
  assign h_end     = ((h_r + FW'(1)) == fill_r);
  assign h_prev    = h_r - FW'(1);
  assign tbl_full  = (used_r == UW'(TYPE_SLOTS));
  assign slot_full = (rd_fill >= FW'(PER_TYPE));
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    idx_nxt    = idx_r;
    h_nxt      = h_r;
    fill_nxt   = fill_r;
    kind_nxt   = kind_r;
    code_nxt   = code_r;
    id_nxt     = id_r;
    status_nxt = status_r;
    out_res_nxt = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    slot_we    = 1'b0;
    slot_waddr = idx_r[SW-1:0];
    slot_wdata = {fill_r - FW'(1), code_r};
    sub_we     = 1'b0;
    sub_waddr  = {idx_r[SW-1:0], h_prev[PW-1:0]};
    sub_wdata  = sub_rdata;

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        h_nxt   = '0;
        if (in_valid) begin
          kind_nxt = in_kind;
          code_nxt = in_event_code;
          id_nxt   = in_subscriber;
          if ((in_kind != esr_pkg::KIND_PUBLISH && in_kind != esr_pkg::KIND_SUBSCRIBE &&
               in_kind != esr_pkg::KIND_UNSUBSCRIBE) ||
              (in_kind != esr_pkg::KIND_PUBLISH && in_subscriber == esr_pkg::NULL_ID)) begin
            status_nxt = esr_pkg::ST_INVALID;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end

      S_SRCH: begin
        if (found) begin
          fill_nxt = rd_fill;
          h_nxt    = '0;
          case (kind_r)
            esr_pkg::KIND_PUBLISH: begin
              status_nxt = esr_pkg::ST_OK;
              state_nxt  = (rd_fill == '0) ? S_RESP : S_PEMIT;
            end
            esr_pkg::KIND_SUBSCRIBE: begin
              state_nxt = S_RESP;
              if (slot_full) begin
                status_nxt = esr_pkg::ST_NO_ROOM;
              end else begin
                status_nxt = esr_pkg::ST_OK;
                sub_we     = 1'b1;
                sub_waddr  = {idx_r[SW-1:0], rd_fill[PW-1:0]};
                sub_wdata  = id_r;
                slot_we    = 1'b1;
                slot_wdata = {rd_fill + FW'(1), code_r};
              end
            end
            esr_pkg::KIND_UNSUBSCRIBE: begin
              if (rd_fill == '0) begin
                status_nxt = esr_pkg::ST_NOT_FOUND;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_USCAN;
              end
            end
            default: begin
              status_nxt = esr_pkg::ST_INVALID;
              state_nxt  = S_RESP;
            end
          endcase
        end else if (miss) begin
          state_nxt = S_RESP;
          case (kind_r)
            esr_pkg::KIND_PUBLISH: begin
              status_nxt = esr_pkg::ST_OK;
            end
            esr_pkg::KIND_SUBSCRIBE: begin
              if (tbl_full) begin
                status_nxt = esr_pkg::ST_NO_ROOM;
              end else begin
                // allocate the next free slot with a one-entry list
                status_nxt = esr_pkg::ST_OK;
                used_nxt   = used_r + UW'(1);
                slot_we    = 1'b1;
                slot_waddr = used_r[SW-1:0];
                slot_wdata = {FW'(1), code_r};
                sub_we     = 1'b1;
                sub_waddr  = {used_r[SW-1:0], {PW{1'b0}}};
                sub_wdata  = id_r;
              end
            end
            esr_pkg::KIND_UNSUBSCRIBE: begin
              status_nxt = esr_pkg::ST_NOT_FOUND;
            end
            default: begin
              status_nxt = esr_pkg::ST_INVALID;
            end
          endcase
        end else begin
          idx_nxt = idx_r + UW'(1);
        end
      end

      S_PEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{status: esr_pkg::ST_OK, target: sub_rdata,
                            target_valid: 1'b1, last: h_end};
          if (h_end) begin
            state_nxt = S_IDLE;
          end else begin
            h_nxt = h_r + FW'(1);
          end
        end
      end

      S_USCAN: begin
        if (sub_rdata == id_r) begin
          if (h_end) begin
            slot_we    = 1'b1;
            status_nxt = esr_pkg::ST_OK;
            state_nxt  = S_RESP;
          end else begin
            h_nxt     = h_r + FW'(1);
            state_nxt = S_USHIFT;
          end
        end else if (h_end) begin
          status_nxt = esr_pkg::ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end else begin
          h_nxt = h_r + FW'(1);
        end
      end

      S_USHIFT: begin
        // move entry h down to h-1
        sub_we = 1'b1;
        if (h_end) begin
          slot_we    = 1'b1;
          status_nxt = esr_pkg::ST_OK;
          state_nxt  = S_RESP;
        end else begin
          h_nxt = h_r + FW'(1);
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{status: status_r, target: esr_pkg::NULL_ID,
                            target_valid: 1'b0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      idx_r       <= '0;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      idx_r       <= idx_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r    <= fill_nxt;
    kind_r    <= kind_nxt;
    code_r    <= code_nxt;
    id_r      <= id_nxt;
    status_r  <= status_nxt;
    out_res_r <= out_res_nxt;
  end

  // read addresses follow the next index so data lines up with idx_r / h_r
  assign slot_raddr = idx_nxt[SW-1:0];
  assign sub_raddr  = {idx_nxt[SW-1:0], h_nxt[PW-1:0]};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

/* src/event_subscription_router.sv */
// top level of the event subscription router
`default_nettype none

// Event subscription router: a routing table of TYPE_SLOTS type slots, each
// binding a 16-bit event code to an ordered list of up to PER_TYPE subscriber
// ids. kind 0 publishes (one result per subscriber in list order, last flag on
// the final one, or a single empty result when there are none), kind 1
// subscribes (appends, allocating a new slot if the code is unknown), kind 2
// unsubscribes (removes the first matching id and closes the gap). Slots are
// never freed. One transaction is worked on at a time: in_stall is high from
// the cycle after acceptance until the last result is placed in the output
// register. The search compares slots one at a time until a hit or a miss (at
// most TYPE_SLOTS), and the list work then takes each delivered id of a
// publish, or each list position scanned or shifted by an unsubscribe (at most
// PER_TYPE), in turn, since the slot memory and the subscriber memory each
// give one read per cycle. A held result never blocks the search of the next
// transaction until a new result is ready.
// Memory contents need no clearing after reset: only allocated slots and
// filled list positions are ever read.

module event_subscription_router #(
  parameter int TYPE_SLOTS = 16,
  parameter int PER_TYPE   = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  // request channel
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire esr_pkg::kind_t  in_kind,
  input  wire esr_pkg::event_t in_event_code,
  input  wire esr_pkg::id_t    in_subscriber,
  // result channel
  output logic                 out_valid,
  input  wire logic            out_stall,
  output esr_pkg::status_t     out_status,
  output esr_pkg::id_t         out_target,
  output logic                 out_target_valid,
  output logic                 out_last
);

  // slot index, fill count and list position widths
  localparam int SW     = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
  localparam int PW     = (PER_TYPE > 1) ? $clog2(PER_TYPE) : 1;
  localparam int FW     = $clog2(PER_TYPE + 1);
  localparam int SLOT_W = FW + esr_pkg::EVENT_W;

  // subscriber memory rows are padded to a power of two so {slot, pos} addresses it
  localparam int SUB_DEPTH = TYPE_SLOTS * (2 ** PW);

  logic              slot_we;
  logic [SW-1:0]     slot_waddr;
  logic [SLOT_W-1:0] slot_wdata;
  logic [SW-1:0]     slot_raddr;
  logic [SLOT_W-1:0] slot_rdata;

  logic              sub_we;
  logic [SW+PW-1:0]  sub_waddr;
  esr_pkg::id_t      sub_wdata;
  logic [SW+PW-1:0]  sub_raddr;
  esr_pkg::id_t      sub_rdata;

  esr_pkg::result_t  out_res;

  // sequencer: search, list edit and the output register
  esr_ctrl #(
    .TYPE_SLOTS (TYPE_SLOTS),
    .PER_TYPE   (PER_TYPE)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_event_code (in_event_code),
    .in_subscriber (in_subscriber),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .slot_we       (slot_we),
    .slot_waddr    (slot_waddr),
    .slot_wdata    (slot_wdata),
    .slot_raddr    (slot_raddr),
    .slot_rdata    (slot_rdata),
    .sub_we        (sub_we),
    .sub_waddr     (sub_waddr),
    .sub_wdata     (sub_wdata),
    .sub_raddr     (sub_raddr),
    .sub_rdata     (sub_rdata)
  );

  // per-slot word: {fill count, event code}
  esr_ram #(
    .WIDTH  (SLOT_W),
    .DEPTH  (TYPE_SLOTS),
    .ADDR_W (SW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // subscriber lists, one row per slot
  esr_ram #(
    .WIDTH  (esr_pkg::ID_W),
    .DEPTH  (SUB_DEPTH),
    .ADDR_W (SW + PW)
  ) u_sub_ram (
    .clk   (clk),
    .we    (sub_we),
    .waddr (sub_waddr),
    .wdata (sub_wdata),
    .raddr (sub_raddr),
    .rdata (sub_rdata)
  );

  assign out_status       = out_res.status;
  assign out_target       = out_res.target;
  assign out_target_valid = out_res.target_valid;
  assign out_last         = out_res.last;

endmodule

`default_nettype wire

/* src/esr_checker.sv */
// port-level checks of the event subscription router, bound to the top level
`default_nettype none

`include "event_subscription_router_macros.svh"

module esr_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire esr_pkg::kind_t   in_kind,
  input wire esr_pkg::event_t  in_event_code,
  input wire esr_pkg::id_t     in_subscriber,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire esr_pkg::status_t out_status,
  input wire esr_pkg::id_t     out_target,
  input wire logic             out_target_valid,
  input wire logic             out_last
);

  // result payload as one vector
  logic [esr_pkg::STATUS_W+esr_pkg::ID_W+1:0] out_payload;
  logic                                       plain_fields_ok;
  logic                                       delivery_fields_ok;

  assign out_payload        = {out_status, out_target, out_target_valid, out_last};
  assign plain_fields_ok    = out_last && (out_target == esr_pkg::NULL_ID);
  assign delivery_fields_ok = (out_status == esr_pkg::ST_OK) &&
                              (out_target != esr_pkg::NULL_ID);

  // a held result keeps its payload
  `ESR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

  // one transaction at a time: busy right after acceptance
  `ESR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // results without a delivered id are single, final and carry no target
  `ESR_ASSERT_NOW(a_plain_result, out_valid && !out_target_valid, plain_fields_ok)

  // delivered ids are never null and always come with ok status
  `ESR_ASSERT_NOW(a_delivery_ok, out_valid && out_target_valid, delivery_fields_ok)

endmodule

bind event_subscription_router esr_checker u_esr_checker (.*);

`default_nettype wire
